// ===== hw/rtl/hbw_pkg.sv =====
package hbw_pkg;

   localparam int CHANNELS   = 16;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int MAX_PERIOD = 128;
   localparam int PHASE_W    = $clog2(MAX_PERIOD);
   localparam int IV_W       = 8;
   localparam int CNT_W      = 8;
   localparam int MS_W       = 16;
   localparam int STEP_W     = $clog2(PHASE_W);

   // ms / 10 as (ms * 0xCCCD) >> 19, exact over the full 16-bit range
   localparam int             TICK_MS     = 10;
   localparam logic [MS_W-1:0] DIV10_MUL  = 16'hCCCD;
   localparam int             DIV10_SHIFT = 19;
   localparam int             PROD_W      = 2 * MS_W;
   localparam int             QUOT_W      = PROD_W - DIV10_SHIFT;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [REQ_USER_W-1:0] {
      OP_TICK       = 3'd0,
      OP_REGISTER   = 3'd1,
      OP_UNREGISTER = 3'd2,
      OP_RELOAD     = 3'd3,
      OP_SET        = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CMD_MOD,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_DIV,
      ST_SCAN_UPD,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic             manual;
      logic [IV_W-1:0]  interval;
      logic [CNT_W-1:0] limit;
      logic [CNT_W-1:0] count;
      logic             reload;
      logic             online;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic            push;
      logic            flush;
      logic [CH_W-1:0] channel;
      logic            online;
   } ev_type;

   typedef struct packed {
      logic               start;
      logic [PHASE_W-1:0] dividend;
      logic [IV_W-1:0]    divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic busy;
      logic zero;
   } mod_sts_type;

endpackage

// ===== hw/rtl/hbw_ram.sv =====
module hbw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/hbw_mod.sv =====
module hbw_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  hbw_pkg::mod_cmd_type cmd,
   output hbw_pkg::mod_sts_type sts
);

   import hbw_pkg::*;

   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [IV_W-1:0]    rem_ff, rem_in;
   logic [PHASE_W-1:0] dvd_ff, dvd_in;
   logic [IV_W-1:0]    dvs_ff, dvs_in;
   logic [IV_W:0]      trial;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, dvd_ff[PHASE_W-1]};
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(PHASE_W - 1);
         rem_in  = '0;
         dvd_in  = cmd.dividend;
         // an interval of zero counts as one
         dvs_in  = (cmd.divisor == '0) ? IV_W'(1) : cmd.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = IV_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = IV_W'(trial);
         end
         dvd_in  = {dvd_ff[PHASE_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.zero = (rem_ff == '0);

endmodule

// ===== hw/rtl/hbw_evq.sv =====
module hbw_evq (
   input  logic                               clock,
   input  logic                               reset,
   input  hbw_pkg::ev_type                    ev,
   output logic                               ev_ready,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hbw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   import hbw_pkg::*;

   logic            pend_vld_ff, pend_vld_in;
   logic [CH_W-1:0] pend_ch_ff, pend_ch_in;
   logic            pend_on_ff, pend_on_in;
   logic            out_vld_ff, out_vld_in;
   logic [CH_W-1:0] out_ch_ff, out_ch_in;
   logic            out_on_ff, out_on_in;
   logic            out_last_ff, out_last_in;
   logic            out_free;

   assign out_free = !out_vld_ff || rsp_tready;
   assign ev_ready = out_free;

   // hold one event back so the final one of a request can carry last
   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_ch_in  = pend_ch_ff;
      pend_on_in  = pend_on_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_ch_in   = out_ch_ff;
      out_on_in   = out_on_ff;
      out_last_in = out_last_ff;
      if ((ev.push || ev.flush) && pend_vld_ff) begin
         out_vld_in  = 1'b1;
         out_ch_in   = pend_ch_ff;
         out_on_in   = pend_on_ff;
         out_last_in = ev.flush;
      end
      if (ev.push) begin
         pend_vld_in = 1'b1;
         pend_ch_in  = ev.channel;
         pend_on_in  = ev.online;
      end else if (ev.flush) begin
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      pend_ch_ff  <= pend_ch_in;
      pend_on_ff  <= pend_on_in;
      out_ch_ff   <= out_ch_in;
      out_on_ff   <= out_on_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_on_ff, out_ch_ff});
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/hbw_engine.sv =====
module hbw_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hbw_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic [hbw_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           ram_we,
   output logic [hbw_pkg::CH_W-1:0]       ram_waddr,
   output hbw_pkg::slot_type              ram_wdata,
   output logic                           ram_re,
   output logic [hbw_pkg::CH_W-1:0]       ram_raddr,
   input  hbw_pkg::slot_type              ram_rdata,
   output hbw_pkg::mod_cmd_type           mod_cmd,
   input  hbw_pkg::mod_sts_type           mod_sts,
   output hbw_pkg::ev_type                ev,
   input  logic                           ev_ready
);

   import hbw_pkg::*;

   state_type          state_ff, state_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CHANNELS-1:0] valid_ff, valid_in;
   logic [CH_W-1:0]    idx_ff, idx_in;

   op_type             op_ff;
   logic [CH_W-1:0]    ch_ff;
   logic               manual_ff;
   logic [CNT_W-1:0]   limit_ff;
   logic               want_ff;
   logic [PROD_W-1:0]  prod_ff;

   logic               accept;
   logic [QUOT_W-1:0]  quot;
   logic [IV_W-1:0]    iv_clamped;
   logic               ch_ok;
   logic               last_idx;
   slot_type           upd;
   logic               upd_emit;
   logic [CNT_W-1:0]   cnt_nx;
   slot_type           set_slot;

   assign accept   = req_tvalid && req_tready;
   assign quot     = prod_ff[PROD_W-1:DIV10_SHIFT];
   assign ch_ok    = ({1'b0, ch_ff} < (CH_W+1)'(CHANNELS));
   assign last_idx = (idx_ff == CH_W'(CHANNELS - 1));

   always_comb begin
      if (quot == '0) begin
         iv_clamped = IV_W'(1);
      end else if (quot > QUOT_W'(MAX_PERIOD)) begin
         iv_clamped = IV_W'(MAX_PERIOD);
      end else begin
         iv_clamped = IV_W'(quot);
      end
   end

   // one check of an automatic channel
   always_comb begin
      upd      = ram_rdata;
      upd_emit = 1'b0;
      cnt_nx   = (ram_rdata.count < ram_rdata.limit) ? ram_rdata.count + 1'b1
                                                     : ram_rdata.count;
      if (ram_rdata.reload) begin
         upd.count  = '0;
         upd.reload = 1'b0;
         if (!ram_rdata.online) begin
            upd.online = 1'b1;
            upd_emit   = 1'b1;
         end
      end else begin
         upd.count = cnt_nx;
         if (cnt_nx >= ram_rdata.limit && ram_rdata.online) begin
            upd.online = 1'b0;
            upd_emit   = 1'b1;
         end
      end
   end

   always_comb begin
      set_slot          = '0;
      set_slot.manual   = manual_ff;
      set_slot.interval = iv_clamped;
      set_slot.limit    = limit_ff;
   end

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      valid_in         = valid_ff;
      idx_in           = idx_ff;
      req_tready       = 1'b0;
      ram_we           = 1'b0;
      ram_waddr        = ch_ff;
      ram_wdata        = ram_rdata;
      ram_re           = 1'b0;
      ram_raddr        = ch_ff;
      mod_cmd.start    = 1'b0;
      mod_cmd.dividend = phase_ff;
      mod_cmd.divisor  = ram_rdata.interval;
      ev.push          = 1'b0;
      ev.flush         = 1'b0;
      ev.channel       = idx_ff;
      ev.online        = upd.online;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            case (op_ff)
               OP_TICK: begin
                  phase_in = (phase_ff == PHASE_W'(MAX_PERIOD - 1)) ? '0
                                                                  : phase_ff + 1'b1;
                  idx_in   = '0;
                  state_in = ST_SCAN_RD;
               end
               OP_REGISTER: begin
                  if (ch_ok) begin
                     ram_we          = 1'b1;
                     ram_wdata       = set_slot;
                     valid_in[ch_ff] = 1'b1;
                  end
               end
               OP_UNREGISTER: begin
                  if (ch_ok) begin
                     valid_in[ch_ff] = 1'b0;
                  end
               end
               OP_RELOAD, OP_SET: begin
                  if (ch_ok && valid_ff[ch_ff]) begin
                     ram_re   = 1'b1;
                     state_in = ST_CMD_MOD;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_CMD_MOD: begin
            ev.channel = ch_ff;
            ev.online  = want_ff;
            if (op_ff == OP_RELOAD) begin
               ram_we           = 1'b1;
               ram_wdata.reload = 1'b1;
               state_in         = ST_IDLE;
            end else if (ram_rdata.manual && want_ff != ram_rdata.online) begin
               if (ev_ready) begin
                  ram_we           = 1'b1;
                  ram_wdata.online = want_ff;
                  ev.push          = 1'b1;
                  state_in         = ST_FLUSH;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN_RD: begin
            if (valid_ff[idx_ff]) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff;
               state_in  = ST_SCAN_CHK;
            end else if (last_idx) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_SCAN_CHK: begin
            if (!ram_rdata.manual) begin
               mod_cmd.start = 1'b1;
               state_in      = ST_SCAN_DIV;
            end else if (last_idx) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end

         ST_SCAN_DIV: begin
            if (!mod_sts.busy) begin
               if (mod_sts.zero) begin
                  state_in = ST_SCAN_UPD;
               end else if (last_idx) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end
         end

         ST_SCAN_UPD: begin
            // stall only when an event must go out and the queue is full
            if (!upd_emit || ev_ready) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               ram_wdata = upd;
               ev.push   = upd_emit;
               if (last_idx) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end
         end

         ST_FLUSH: begin
            if (ev_ready) begin
               ev.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         valid_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // capture the request; the divide-by-ten product settles during decode
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_type'(req_tuser);
         ch_ff     <= req_tdata[CH_W-1:0];
         manual_ff <= req_tdata[CH_W];
         limit_ff  <= req_tdata[CH_W+1+MS_W +: CNT_W];
         want_ff   <= req_tdata[CH_W+1+MS_W+CNT_W];
         prod_ff   <= PROD_W'(req_tdata[CH_W+1 +: MS_W]) * PROD_W'(DIV10_MUL);
      end
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("slot memory read and written in one cycle");

   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      (ev.push || ev.flush) |-> ev_ready)
      else $error("event moved while the output stage is full");

   a_mod_idle_start: assert property (@(posedge clock) disable iff (reset)
      mod_cmd.start |-> !mod_sts.busy)
      else $error("remainder unit restarted while busy");

   a_flush_ends: assert property (@(posedge clock) disable iff (reset)
      ev.flush |=> state_ff == ST_IDLE)
      else $error("request did not end after flush");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, phase_ff} < (PHASE_W+1)'(MAX_PERIOD))
      else $error("phase out of range");

endmodule

// ===== hw/rtl/heartbeat_watchdog_bank.sv =====
// Bank of heartbeat watchdog channels addressed by index.
// Request channel (req_*): req_tuser carries the command (tick, register,
// unregister, reload, set state), req_tdata the channel and its arguments.
// Response channel (rsp_*): one item per change of a channel's online state;
// rsp_tlast marks the final item caused by one request.
// Commands other than tick return to ready after decode; reload and set state
// first read the slot, and a set that changes a manual slot pushes and flushes
// its event, waiting while the output stage is full. A tick walks all 16 slots
// through the slot memory and shares one bit-serial remainder unit: an unused
// slot is skipped, a manual slot is read and checked, and an automatic slot is
// read, checked, divided and written back on a zero remainder. Each event is
// held until the next event of its request or the flush moves it to rsp_*.
// Reset clears the phase counter and all slot valid bits; no memory sweep.
// A stalled receiver holds the response register and one pending event; the
// walk then waits at the next event it finds, and a new request is accepted
// as soon as the previous one has handed over its last event.
module heartbeat_watchdog_bank (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // opcode[2:0]
   input  logic [hbw_pkg::REQ_USER_W-1:0] req_tuser,
   // channel[3:0], manual_mode[4], interval_ms[20:5], timeout_limit[28:21],
   // new_state[29], zero[31:30]
   input  logic [hbw_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // event_channel[3:0], online[4], zero[7:5]
   output logic [hbw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   import hbw_pkg::*;

   logic            ram_we;
   logic [CH_W-1:0] ram_waddr;
   slot_type        ram_wdata;
   logic            ram_re;
   logic [CH_W-1:0] ram_raddr;
   slot_type        ram_rdata;
   mod_cmd_type     mod_cmd;
   mod_sts_type     mod_sts;
   ev_type          ev;
   logic            ev_ready;

   hbw_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (CHANNELS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   hbw_mod u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .sts   (mod_sts)
   );

   hbw_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .mod_cmd    (mod_cmd),
      .mod_sts    (mod_sts),
      .ev         (ev),
      .ev_ready   (ev_ready)
   );

   hbw_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .ev         (ev),
      .ev_ready   (ev_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
